// ----- src/eemi_pkg.sv -----
// Shared types for the modular inverse block.
// No dependencies; used by the divider and the top level.
package eemi_pkg;

    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

// ----- src/eemi_in_if.sv -----
// Input channel: one word carries value and modulus.
// No dependencies.
interface eemi_in_if #(parameter int WIDTH = 32);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] value;
    logic [WIDTH-1:0] modulus;

    modport source (output valid, value, modulus, input ready);
    modport sink   (input valid, value, modulus, output ready);
endinterface

// ----- src/eemi_out_if.sv -----
// Output channel: one word carries inverse and has_inverse.
// No dependencies.
interface eemi_out_if #(parameter int WIDTH = 32);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] inverse;
    logic             has_inverse;

    modport source (output valid, inverse, has_inverse, input ready);
    modport sink   (input valid, inverse, has_inverse, output ready);
endinterface

// ----- src/eemi_div.sv -----
// Radix-2 restoring divider with a Horner shift-add product of quotient and mult.
// Depends on eemi_pkg.
module eemi_div #(
    parameter int WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  eemi_pkg::div_ctl_t   ctl,
    input  logic [WIDTH-1:0]     dividend,
    input  logic [WIDTH-1:0]     divisor,
    input  logic [WIDTH-1:0]     mult,
    output eemi_pkg::div_sts_t   sts,
    output logic [WIDTH-1:0]     remainder,
    output logic [WIDTH-1:0]     product
);
    import eemi_pkg::*;

    localparam int CW = $clog2(WIDTH + 1);

    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] dvs_reg;
    logic [WIDTH-1:0] mul_reg;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             ge;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[WIDTH-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = trial >= {1'b0, dvs_reg};
        rem_next = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
        quo_next = {quo_reg[WIDTH-2:0], ge};
        acc_next = {acc_reg[WIDTH-2:0], 1'b0} + (ge ? mul_reg : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !ctl.start && busy_reg && (cnt_reg == CW'(1));
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(WIDTH);
                rem_reg  <= '0;
                acc_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
                mul_reg  <= mult;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                acc_reg <= acc_next;
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign remainder = rem_reg;
    assign product   = acc_reg;

endmodule

// ----- src/extended_euclid_mod_inverse_top.sv -----
// Top level of the modular inverse block: sequencer, Euclid state, output register.
// Depends on eemi_pkg, eemi_in_if, eemi_out_if and eemi_div.
//
// Takes one word {value, modulus} and returns one word {inverse, has_inverse} with
// inverse = value^-1 mod modulus, or zero with has_inverse low when gcd != 1 or
// modulus is zero. Every Euclid step, and the initial reduction of value, runs one full
// pass of the shared bit-serial divider, which also forms the cofactor product.
// in_ch.ready is high only between words; a finished result waits in the output
// register while the next word is taken.
module extended_euclid_mod_inverse_top #(
    parameter int WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    eemi_in_if.sink     in_ch,
    eemi_out_if.source  out_ch
);
    import eemi_pkg::*;

    typedef enum logic [2:0] {
        IDLE,
        REDUCE,
        CHECK,
        STEP,
        FIX,
        EMIT
    } state_t;

    state_t           state_reg;
    logic [WIDTH-1:0] m_reg;
    logic [WIDTH-1:0] r0_reg, r1_reg;
    logic [WIDTH-1:0] mag0_reg, mag1_reg;
    logic             neg0_reg, neg1_reg;
    logic [WIDTH-1:0] div_a_reg, div_b_reg;
    logic             start_reg;
    logic             out_valid_reg;
    logic [WIDTH-1:0] out_inv_reg;
    logic             out_ok_reg;

    div_ctl_t         div_ctl;
    div_sts_t         div_sts;
    logic [WIDTH-1:0] div_rem;
    logic [WIDTH-1:0] div_prod;
    logic             in_fire;
    logic             out_free;
    logic             ok;
    logic [WIDTH-1:0] inv_calc;

    assign div_ctl.start = start_reg;

    eemi_div #(.WIDTH(WIDTH)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (div_a_reg),
        .divisor   (div_b_reg),
        .mult      (mag1_reg),
        .sts       (div_sts),
        .remainder (div_rem),
        .product   (div_prod)
    );

    assign in_ch.ready = (state_reg == IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        ok = (r0_reg == WIDTH'(1));
        if (!ok || mag0_reg == '0)
            inv_calc = '0;
        else if (neg0_reg)
            inv_calc = m_reg - mag0_reg;
        else
            inv_calc = mag0_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= ((state_reg == IDLE) && in_fire && (in_ch.modulus != '0)) ||
                         ((state_reg == CHECK) && (r1_reg != '0) && !div_sts.busy);
            if (out_valid_reg && out_ch.ready && (state_reg != EMIT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                IDLE:
                begin
                    if (in_fire)
                    begin
                        m_reg <= in_ch.modulus;
                        if (in_ch.modulus == '0)
                        begin
                            r0_reg    <= '0;
                            r1_reg    <= '0;
                            mag0_reg  <= '0;
                            neg0_reg  <= 1'b0;
                            state_reg <= CHECK;
                        end
                        else
                        begin
                            div_a_reg <= in_ch.value;
                            div_b_reg <= in_ch.modulus;
                            state_reg <= REDUCE;
                        end
                    end
                end
                REDUCE:
                begin
                    if (div_sts.done)
                    begin
                        r0_reg    <= m_reg;
                        r1_reg    <= div_rem;
                        mag0_reg  <= '0;
                        mag1_reg  <= WIDTH'(1);
                        neg0_reg  <= 1'b0;
                        neg1_reg  <= 1'b0;
                        state_reg <= CHECK;
                    end
                end
                CHECK:
                begin
                    if (r1_reg == '0)
                        state_reg <= FIX;
                    else if (!div_sts.busy)
                    begin
                        div_a_reg <= r0_reg;
                        div_b_reg <= r1_reg;
                        state_reg <= STEP;
                    end
                end
                STEP:
                begin
                    if (div_sts.done)
                    begin
                        r0_reg    <= r1_reg;
                        r1_reg    <= div_rem;
                        mag0_reg  <= mag1_reg;
                        mag1_reg  <= mag0_reg + div_prod;
                        neg0_reg  <= neg1_reg;
                        neg1_reg  <= !neg1_reg;
                        state_reg <= CHECK;
                    end
                end
                FIX:
                begin
                    if (mag0_reg >= m_reg)
                        mag0_reg <= mag0_reg - m_reg;
                    state_reg <= EMIT;
                end
                EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_inv_reg   <= inv_calc;
                        out_ok_reg    <= ok;
                        state_reg     <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.inverse     = out_inv_reg;
    assign out_ch.has_inverse = out_ok_reg;

endmodule

// ----- src/eemi_chk.sv -----
// Port-level checks for the modular inverse block, bound to the top level.
// Depends on extended_euclid_mod_inverse_top and its channel interfaces.
module eemi_chk #(
    parameter int WIDTH = 32
) (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [WIDTH-1:0] inverse,
    input logic             has_inverse
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(inverse) && $stable(has_inverse))
        else $error("result word dropped or changed while stalled");

    a_no_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_inverse |-> inverse == '0)
        else $error("nonzero inverse without has_inverse");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again before the word was processed");

    a_ready_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("not ready for a new word after producing a result");

endmodule

bind extended_euclid_mod_inverse_top eemi_chk #(.WIDTH(WIDTH)) u_eemi_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .inverse     (out_ch.inverse),
    .has_inverse (out_ch.has_inverse)
);

// ----- sim/eemi_inverse_checker.sv -----
// Checker for the modular inverse block: watches both channels, predicts each result
// word from the accepted input word and compares field by field.
// Depends on eemi_in_if and eemi_out_if.
module eemi_inverse_checker #(
    parameter int WIDTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    eemi_in_if   in_ch,
    eemi_out_if  out_ch,
    output int   error_count,
    output int   words_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [WIDTH-1:0] inverse;
        logic             has_inverse;
    } inverse_word_t;

    inverse_word_t pending_inverses[$];

    // Extended Euclid on (modulus, value mod modulus); cofactor kept as magnitude and sign.
    function automatic inverse_word_t modinv_expected(input logic [WIDTH-1:0] value,
                                                      input logic [WIDTH-1:0] modulus);
        logic [WIDTH-1:0] rem_a, rem_b, rem_next, quot;
        logic [WIDTH-1:0] mag_a, mag_b, mag_next;
        logic             neg_a, neg_b, neg_next;
        inverse_word_t    res;
        res = '0;
        if (modulus != '0)
        begin
            rem_a = modulus;
            rem_b = value % modulus;
            mag_a = '0;
            neg_a = 1'b0;
            mag_b = WIDTH'(1);
            neg_b = 1'b0;
            while (rem_b != '0)
            begin
                quot     = rem_a / rem_b;
                rem_next = rem_a - quot * rem_b;
                mag_next = mag_a + quot * mag_b;
                neg_next = !neg_b;
                rem_a    = rem_b;
                rem_b    = rem_next;
                mag_a    = mag_b;
                neg_a    = neg_b;
                mag_b    = mag_next;
                neg_b    = neg_next;
            end
            if (rem_a == WIDTH'(1))
            begin
                res.has_inverse = 1'b1;
                mag_a = mag_a % modulus;
                if (mag_a == '0)
                    res.inverse = '0;
                else
                    res.inverse = neg_a ? (modulus - mag_a) : mag_a;
            end
        end
        return res;
    endfunction

    initial
    begin
        error_count     = 0;
        words_in_flight = 0;
    end

    always @(posedge clk)
    begin : monitor
        inverse_word_t want;
        int            bad;
        bad = 0;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                pending_inverses.push_back(modinv_expected(in_ch.value, in_ch.modulus));
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_inverses.size() == 0)
                begin
                    $error("result word with none expected: inverse %0h has_inverse %0b",
                           out_ch.inverse, out_ch.has_inverse);
                    bad++;
                end
                else
                begin
                    want = pending_inverses.pop_front();
                    if (out_ch.inverse !== want.inverse)
                    begin
                        $error("inverse: expected %0h, got %0h", want.inverse, out_ch.inverse);
                        bad++;
                    end
                    if (out_ch.has_inverse !== want.has_inverse)
                    begin
                        $error("has_inverse: expected %0b, got %0b",
                               want.has_inverse, out_ch.has_inverse);
                        bad++;
                    end
                end
            end
            error_count     <= error_count + bad;
            words_in_flight <= pending_inverses.size();
        end
    end

endmodule

// ----- sim/tb_extended_euclid_mod_inverse_top.sv -----
// Testbench top for the modular inverse block: clock, reset, directed and random words,
// receiver back-pressure, watchdog and verdict.
// Depends on eemi_in_if, eemi_out_if, extended_euclid_mod_inverse_top and eemi_inverse_checker.
module tb_extended_euclid_mod_inverse_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDTH        = 32;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    localparam int LONG_HOLD    = 3000;
    localparam int SETTLE       = 2000;
    localparam int STALL_LIMIT  = 20000;
    localparam int PHASE_WORDS  = 245;

    logic clk = 1'b0;
    logic rst_n;
    logic start_long_hold;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   hold_left;
    int   quiet_cycles;
    int   error_count;
    int   words_in_flight;

    eemi_in_if  #(.WIDTH(WIDTH)) in_ch ();
    eemi_out_if #(.WIDTH(WIDTH)) out_ch ();

    extended_euclid_mod_inverse_top #(.WIDTH(WIDTH)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    eemi_inverse_checker #(.WIDTH(WIDTH)) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .error_count     (error_count),
        .words_in_flight (words_in_flight)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        out_ch.ready <= 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (start_long_hold)
                hold_left = LONG_HOLD;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_word(input logic [WIDTH-1:0] v, input logic [WIDTH-1:0] m);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.value   <= v;
        in_ch.modulus <= m;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (words_in_flight != 0)
            @(posedge clk);
    endtask

    task automatic send_random_words(input int count);
        logic [WIDTH-1:0] v, m, f;
        int unsigned      kind;
        repeat (count)
        begin
            kind = $urandom_range(99);
            if (kind < 40)
            begin
                v = $urandom;
                m = $urandom;
            end
            else if (kind < 65)
            begin
                m = $urandom_range(255, 2);
                v = $urandom_range(1023);
            end
            else if (kind < 78)
            begin
                m = $urandom_range(65535, 2);
                v = $urandom;
            end
            else if (kind < 90)
            begin
                // shared factor or exact multiple: no inverse
                f = $urandom_range(16, 2);
                m = f * $urandom_range(1 << 20, 1);
                if ($urandom_range(3) == 0)
                    v = m * $urandom_range(3);
                else
                    v = f * $urandom_range(1 << 20);
            end
            else if (kind < 95)
            begin
                m = $urandom_range(1);
                v = $urandom;
            end
            else
            begin
                m = 32'hFFFF_FFFB;
                v = $urandom;
            end
            send_word(v, m);
        end
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        start_long_hold <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.value     <= '0;
        in_ch.modulus   <= '0;
        quiet_cycles    <= 0;
        tx_idle_pct = 12;
        rx_idle_pct = 83;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(32'd0, 32'd2);
        send_word(32'd1, 32'd2);
        send_word(32'd3, 32'd7);
        send_word(32'd7, 32'd3);
        send_word(32'd10, 32'd5);
        send_word(32'd0, 32'd0);
        send_word(32'd5, 32'd0);
        send_word(32'hFFFF_FFFF, 32'd0);
        send_word(32'd123, 32'd1);
        send_word(32'd0, 32'd1);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_word(32'd1, 32'hFFFF_FFFF);
        send_word(32'd1836311903, 32'd2971215073);
        send_word(32'd2971215073, 32'd1836311903);
        send_word(32'd12, 32'd18);
        send_word(32'd2, 32'h8000_0000);
        send_word(32'd3, 32'h8000_0000);
        send_word(32'h8000_0000, 32'd3);
        send_word(32'd65537, 32'hFFFF_FFFB);
        send_word(32'hAAAA_AAAA, 32'h5555_5555);
        send_word(32'h5555_5555, 32'hAAAA_AAAB);

        send_random_words(PHASE_WORDS);
        wait_drained();

        tx_idle_pct = 83;
        rx_idle_pct = 12;
        send_random_words(PHASE_WORDS);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        start_long_hold <= 1'b1;
        @(posedge clk);
        start_long_hold <= 1'b0;
        send_random_words(PHASE_WORDS);
        wait_drained();
        repeat (SETTLE) @(posedge clk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
